### rtl/core/bsrm_pkg.sv
package bsrm_pkg;

    // table geometry
    localparam int ENTRIES    = 8;
    localparam int PAGE_SHIFT = 12;
    localparam int MAX_PAGES  = 128;

    // port field widths
    localparam int CMD_W    = 3;
    localparam int OWNER_W  = 6;
    localparam int ADDR_W   = 32;
    localparam int PAGE_W   = 20;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 8;
    localparam int FOUND_W  = 3;
    localparam int OFFSET_W = 7;

    // derived widths
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int VPAGE_W  = ADDR_W - PAGE_SHIFT;
    localparam int PROBE_W  = (VPAGE_W > PAGE_W) ? VPAGE_W : PAGE_W;
    localparam int CMP_W    = PROBE_W + 1;

    localparam logic [INDEX_W:0]   ENTRIES_C   = (INDEX_W + 1)'(ENTRIES);
    localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(ENTRIES - 1);
    localparam logic [COUNT_W-1:0] MAX_PAGES_C = COUNT_W'(MAX_PAGES);

    // command codes
    localparam logic [CMD_W-1:0] CMD_GET_FREE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MAP      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UNMAP    = 3'd4;

    typedef struct packed {
        logic               mapped;
        logic [OWNER_W-1:0] owner;
        logic [PAGE_W-1:0]  base_page;
        logic [COUNT_W-1:0] page_count;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic exec;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_scan;
        logic scan_hit;
        logic scan_last;
    } dp_stat_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EXEC = 3'b100
    } state_t;

endpackage

### rtl/core/bsrm_ctrl.sv
module bsrm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  bsrm_pkg::dp_stat_t stat,
    output bsrm_pkg::dp_cmd_t  cmd
);

    bsrm_pkg::state_t state_reg;
    bsrm_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == bsrm_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd.capture   = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.exec      = 1'b0;
        case (state_reg)
            bsrm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = stat.needs_scan ? bsrm_pkg::S_SCAN : bsrm_pkg::S_EXEC;
                end
            end
            bsrm_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit || stat.scan_last)
                begin
                    state_next = bsrm_pkg::S_EXEC;
                end
            end
            bsrm_pkg::S_EXEC:
            begin
                // wait for the previous result to drain before committing
                if (out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = bsrm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bsrm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsrm_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/bsrm_datapath.sv
module bsrm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bsrm_pkg::dp_cmd_t                   cmd,
    output bsrm_pkg::dp_stat_t                  stat,
    input  logic [bsrm_pkg::CMD_W-1:0]          command,
    input  logic [bsrm_pkg::OWNER_W-1:0]        owner_id,
    input  logic [bsrm_pkg::ADDR_W-1:0]         virtual_address,
    input  logic [bsrm_pkg::PAGE_W-1:0]         page_number,
    input  logic [bsrm_pkg::INDEX_W-1:0]        entry_index,
    input  logic [bsrm_pkg::COUNT_W-1:0]        page_count,
    input  logic                                unmap_any_page,
    output logic                                status,
    output logic [bsrm_pkg::FOUND_W-1:0]        found_index,
    output logic [bsrm_pkg::OFFSET_W-1:0]       page_offset
);

    bsrm_pkg::entry_t entry_reg [bsrm_pkg::ENTRIES];

    // captured command
    logic [bsrm_pkg::CMD_W-1:0]    cmd_reg;
    logic [bsrm_pkg::OWNER_W-1:0]  owner_reg;
    logic [bsrm_pkg::PROBE_W-1:0]  probe_reg;
    logic [bsrm_pkg::INDEX_W-1:0]  idx_reg;
    logic [bsrm_pkg::COUNT_W-1:0]  count_reg;
    logic                          any_reg;

    // scan state
    logic [bsrm_pkg::IDX_W-1:0]    scan_idx_reg;
    logic                          hit_reg;
    logic [bsrm_pkg::IDX_W-1:0]    hit_idx_reg;
    logic [bsrm_pkg::OFFSET_W-1:0] hit_offset_reg;
    logic                          base_match_reg;

    // result registers
    logic                          status_reg;
    logic [bsrm_pkg::FOUND_W-1:0]  found_reg;
    logic [bsrm_pkg::OFFSET_W-1:0] offset_reg;

    logic [bsrm_pkg::PROBE_W-1:0]  probe_in;
    logic [bsrm_pkg::IDX_W-1:0]    rd_addr;
    bsrm_pkg::entry_t              rd_entry;
    logic [bsrm_pkg::CMP_W-1:0]    probe_ext;
    logic [bsrm_pkg::CMP_W-1:0]    base_ext;
    logic [bsrm_pkg::CMP_W-1:0]    end_ext;
    logic [bsrm_pkg::CMP_W-1:0]    diff;
    logic                          covers;
    logic                          cur_hit;
    logic                          idx_in_range;

    logic                          res_status;
    logic [bsrm_pkg::FOUND_W-1:0]  res_found;
    logic [bsrm_pkg::OFFSET_W-1:0] res_offset;
    logic                          wr_en;
    logic [bsrm_pkg::IDX_W-1:0]    wr_addr;
    bsrm_pkg::entry_t              wr_data;

    always_comb
    begin
        if (command == bsrm_pkg::CMD_LOOKUP)
        begin
            probe_in = bsrm_pkg::PROBE_W'(virtual_address >> bsrm_pkg::PAGE_SHIFT);
        end
        else
        begin
            probe_in = bsrm_pkg::PROBE_W'(page_number);
        end
    end

    assign stat.needs_scan = (command == bsrm_pkg::CMD_GET_FREE) ||
                             (command == bsrm_pkg::CMD_LOOKUP) ||
                             (command == bsrm_pkg::CMD_UNMAP);

    assign rd_addr  = cmd.scan_step ? scan_idx_reg : idx_reg[bsrm_pkg::IDX_W-1:0];
    assign rd_entry = entry_reg[rd_addr];

    // range test without wrap
    assign probe_ext = bsrm_pkg::CMP_W'(probe_reg);
    assign base_ext  = bsrm_pkg::CMP_W'(rd_entry.base_page);
    assign end_ext   = base_ext + bsrm_pkg::CMP_W'(rd_entry.page_count);
    assign diff      = probe_ext - base_ext;
    assign covers    = rd_entry.mapped && (rd_entry.owner == owner_reg) &&
                       (probe_ext >= base_ext) && (probe_ext < end_ext);

    always_comb
    begin
        if (cmd_reg == bsrm_pkg::CMD_GET_FREE)
        begin
            cur_hit = !rd_entry.mapped;
        end
        else
        begin
            cur_hit = covers;
        end
    end

    assign stat.scan_hit  = cur_hit;
    assign stat.scan_last = (scan_idx_reg == bsrm_pkg::LAST_IDX);

    assign idx_in_range = ({1'b0, idx_reg} < bsrm_pkg::ENTRIES_C);

    always_comb
    begin
        res_status = 1'b1;
        res_found  = '0;
        res_offset = '0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[bsrm_pkg::IDX_W-1:0];
        wr_data    = '0;
        case (cmd_reg)
            bsrm_pkg::CMD_GET_FREE:
            begin
                if (hit_reg)
                begin
                    res_status = 1'b0;
                    res_found  = bsrm_pkg::FOUND_W'(hit_idx_reg);
                end
            end
            bsrm_pkg::CMD_FREE:
            begin
                if (idx_in_range)
                begin
                    res_status = 1'b0;
                    wr_en      = 1'b1;
                end
            end
            bsrm_pkg::CMD_LOOKUP:
            begin
                if (hit_reg)
                begin
                    res_status = 1'b0;
                    res_found  = bsrm_pkg::FOUND_W'(hit_idx_reg);
                    res_offset = hit_offset_reg;
                end
            end
            bsrm_pkg::CMD_MAP:
            begin
                if (idx_in_range && (count_reg != '0) && (count_reg <= bsrm_pkg::MAX_PAGES_C) &&
                    !((rd_entry.page_count != '0) && (count_reg > rd_entry.page_count)) &&
                    !(rd_entry.mapped && (rd_entry.owner != owner_reg)))
                begin
                    res_status         = 1'b0;
                    wr_en              = 1'b1;
                    wr_data.mapped     = 1'b1;
                    wr_data.owner      = owner_reg;
                    wr_data.base_page  = bsrm_pkg::PAGE_W'(probe_reg);
                    wr_data.page_count = count_reg;
                end
            end
            bsrm_pkg::CMD_UNMAP:
            begin
                wr_addr = hit_idx_reg;
                if (hit_reg && (base_match_reg || any_reg))
                begin
                    res_status = 1'b0;
                    wr_en      = 1'b1;
                end
            end
            default:
            begin
                res_status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= command;
            owner_reg <= owner_id;
            probe_reg <= probe_in;
            idx_reg   <= entry_index;
            count_reg <= page_count;
            any_reg   <= unmap_any_page;
        end
        if (cmd.scan_step && cur_hit)
        begin
            hit_idx_reg    <= scan_idx_reg;
            hit_offset_reg <= bsrm_pkg::OFFSET_W'(diff);
            base_match_reg <= (probe_reg == bsrm_pkg::PROBE_W'(rd_entry.base_page));
        end
        if (cmd.exec)
        begin
            status_reg <= res_status;
            found_reg  <= res_found;
            offset_reg <= res_offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            hit_reg      <= 1'b0;
        end
        else if (cmd.capture)
        begin
            scan_idx_reg <= '0;
            hit_reg      <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (cur_hit)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bsrm_pkg::ENTRIES; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < bsrm_pkg::ENTRIES; i++)
            begin
                if (cmd.exec && wr_en && (wr_addr == bsrm_pkg::IDX_W'(i)))
                begin
                    entry_reg[i] <= wr_data;
                end
            end
        end
    end

    assign status      = status_reg;
    assign found_index = found_reg;
    assign page_offset = offset_reg;

endmodule

### rtl/core/backing_store_range_map.sv
// Free entry and map go from capture straight to the commit state; get free, lookup and
// unmap first scan the table one entry per cycle, stopping at the first hit or the last entry.
// One command at a time: in_ready is high only while idle, and a waiting result holds the commit;
// the per-entry scan over ENTRIES (8) bounds how long a scanning command runs.
// A new command may be accepted while the previous result waits in the output register.
// Reset (rst_n, async, active low) clears the table to unmapped and drops all valids.
module backing_store_range_map (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bsrm_pkg::CMD_W-1:0]          command,
    input  logic [bsrm_pkg::OWNER_W-1:0]        owner_id,
    input  logic [bsrm_pkg::ADDR_W-1:0]         virtual_address,
    input  logic [bsrm_pkg::PAGE_W-1:0]         page_number,
    input  logic [bsrm_pkg::INDEX_W-1:0]        entry_index,
    input  logic [bsrm_pkg::COUNT_W-1:0]        page_count,
    input  logic                                unmap_any_page,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                status,
    output logic [bsrm_pkg::FOUND_W-1:0]        found_index,
    output logic [bsrm_pkg::OFFSET_W-1:0]       page_offset
);

    bsrm_pkg::dp_cmd_t  dp_cmd;
    bsrm_pkg::dp_stat_t dp_stat;

    bsrm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    bsrm_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .stat            (dp_stat),
        .command         (command),
        .owner_id        (owner_id),
        .virtual_address (virtual_address),
        .page_number     (page_number),
        .entry_index     (entry_index),
        .page_count      (page_count),
        .unmap_any_page  (unmap_any_page),
        .status          (status),
        .found_index     (found_index),
        .page_offset     (page_offset)
    );

endmodule

### dv/backing_store_range_map_tb.sv
module backing_store_range_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bsrm_pkg::CMD_W-1:0] CMD_RESERVED_LO =
        bsrm_pkg::CMD_W'(bsrm_pkg::CMD_UNMAP + 1);
    localparam logic [bsrm_pkg::CMD_W-1:0] CMD_RESERVED_HI = '1;
    localparam int                         CYCLE_LIMIT     = 500000;
    localparam int                         DRAIN_CYCLES    = 40;
    localparam int                         RANDOM_ITEMS    = 1640;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    typedef struct {
        logic [bsrm_pkg::CMD_W-1:0]   cmd;
        logic [bsrm_pkg::OWNER_W-1:0] owner;
        logic [bsrm_pkg::ADDR_W-1:0]  vaddr;
        logic [bsrm_pkg::PAGE_W-1:0]  page;
        logic [bsrm_pkg::INDEX_W-1:0] idx;
        logic [bsrm_pkg::COUNT_W-1:0] count;
        logic                         any;
    } map_cmd_t;

    typedef struct {
        logic [bsrm_pkg::CMD_W-1:0]    cmd;
        logic                          status;
        logic [bsrm_pkg::FOUND_W-1:0]  found;
        logic [bsrm_pkg::OFFSET_W-1:0] offset;
    } map_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [bsrm_pkg::CMD_W-1:0]    command = '0;
    logic [bsrm_pkg::OWNER_W-1:0]  owner_id = '0;
    logic [bsrm_pkg::ADDR_W-1:0]   virtual_address = '0;
    logic [bsrm_pkg::PAGE_W-1:0]   page_number = '0;
    logic [bsrm_pkg::INDEX_W-1:0]  entry_index = '0;
    logic [bsrm_pkg::COUNT_W-1:0]  page_count = '0;
    logic                          unmap_any_page = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          status;
    logic [bsrm_pkg::FOUND_W-1:0]  found_index;
    logic [bsrm_pkg::OFFSET_W-1:0] page_offset;

    // shadow copy of the table
    logic                         slot_mapped [bsrm_pkg::ENTRIES];
    logic [bsrm_pkg::OWNER_W-1:0] slot_owner  [bsrm_pkg::ENTRIES];
    logic [bsrm_pkg::PAGE_W-1:0]  slot_base   [bsrm_pkg::ENTRIES];
    logic [bsrm_pkg::COUNT_W-1:0] slot_count  [bsrm_pkg::ENTRIES];

    map_result_t expected_results[$];
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    bit          sender_gaps = 1'b1;
    rx_mode_t    rx_mode = RX_ALWAYS;
    int          rx_hold_left = 0;
    int unsigned rx_phase = 0;

    backing_store_range_map u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .owner_id        (owner_id),
        .virtual_address (virtual_address),
        .page_number     (page_number),
        .entry_index     (entry_index),
        .page_count      (page_count),
        .unmap_any_page  (unmap_any_page),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .found_index     (found_index),
        .page_offset     (page_offset)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_slot(int s);
        slot_mapped[s] = 1'b0;
        slot_owner[s]  = '0;
        slot_base[s]   = '0;
        slot_count[s]  = '0;
    endfunction

    // lowest mapped slot of this owner whose range holds the page, -1 if none
    function automatic int covering_slot(logic [bsrm_pkg::OWNER_W-1:0] owner,
                                         longint unsigned page);
        longint unsigned base;
        for (int s = 0; s < bsrm_pkg::ENTRIES; s++)
        begin
            base = slot_base[s];
            if (slot_mapped[s] && slot_owner[s] == owner && page >= base &&
                page < base + slot_count[s])
                return s;
        end
        return -1;
    endfunction

    function automatic map_result_t apply_command(map_cmd_t c);
        map_result_t                  r;
        int                           s;
        bit                           ok;
        logic [bsrm_pkg::VPAGE_W-1:0] vpage;
        r.cmd    = c.cmd;
        r.status = 1'b1;
        r.found  = '0;
        r.offset = '0;
        case (c.cmd)
            bsrm_pkg::CMD_GET_FREE:
            begin
                for (s = 0; s < bsrm_pkg::ENTRIES; s++)
                begin
                    if (!slot_mapped[s])
                    begin
                        r.status = 1'b0;
                        r.found  = bsrm_pkg::FOUND_W'(s);
                        break;
                    end
                end
            end
            bsrm_pkg::CMD_FREE:
            begin
                if (c.idx < bsrm_pkg::ENTRIES)
                begin
                    clear_slot(c.idx);
                    r.status = 1'b0;
                end
            end
            bsrm_pkg::CMD_LOOKUP:
            begin
                vpage = c.vaddr >> bsrm_pkg::PAGE_SHIFT;
                s = covering_slot(c.owner, vpage);
                if (s >= 0)
                begin
                    r.status = 1'b0;
                    r.found  = bsrm_pkg::FOUND_W'(s);
                    r.offset = bsrm_pkg::OFFSET_W'(vpage - slot_base[s]);
                end
            end
            bsrm_pkg::CMD_MAP:
            begin
                ok = c.idx < bsrm_pkg::ENTRIES && c.count >= 1 &&
                     c.count <= bsrm_pkg::MAX_PAGES;
                if (ok && slot_count[c.idx] > 0 && c.count > slot_count[c.idx])
                    ok = 1'b0;
                if (ok && slot_mapped[c.idx] && slot_owner[c.idx] != c.owner)
                    ok = 1'b0;
                if (ok)
                begin
                    slot_mapped[c.idx] = 1'b1;
                    slot_owner[c.idx]  = c.owner;
                    slot_base[c.idx]   = c.page;
                    slot_count[c.idx]  = c.count;
                    r.status = 1'b0;
                end
            end
            bsrm_pkg::CMD_UNMAP:
            begin
                s = covering_slot(c.owner, c.page);
                if (s >= 0 && (c.page == slot_base[s] || c.any))
                begin
                    clear_slot(s);
                    r.status = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic idle_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic issue_command(map_cmd_t c);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (sender_gaps)
                idle_sender($urandom_range(1, 6));
        end
        burst_left--;
        @(negedge clk);
        in_valid        <= 1'b1;
        command         <= c.cmd;
        owner_id        <= c.owner;
        virtual_address <= c.vaddr;
        page_number     <= c.page;
        entry_index     <= c.idx;
        page_count      <= c.count;
        unmap_any_page  <= c.any;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(apply_command(c));
    endtask

    task automatic wait_for_drain();
        idle_sender(1);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic map_cmd_t make_cmd(logic [bsrm_pkg::CMD_W-1:0]   cmd,
                                          logic [bsrm_pkg::OWNER_W-1:0] owner,
                                          logic [bsrm_pkg::ADDR_W-1:0]  vaddr,
                                          logic [bsrm_pkg::PAGE_W-1:0]  page,
                                          logic [bsrm_pkg::INDEX_W-1:0] idx,
                                          logic [bsrm_pkg::COUNT_W-1:0] count,
                                          logic                         any);
        map_cmd_t c;
        c.cmd   = cmd;
        c.owner = owner;
        c.vaddr = vaddr;
        c.page  = page;
        c.idx   = idx;
        c.count = count;
        c.any   = any;
        return c;
    endfunction

    function automatic int pick_mapped_slot();
        int live[$];
        for (int s = 0; s < bsrm_pkg::ENTRIES; s++)
            if (slot_mapped[s])
                live.push_back(s);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function automatic logic [bsrm_pkg::OWNER_W-1:0] pick_owner();
        if ($urandom_range(0, 9) == 0)
            return bsrm_pkg::OWNER_W'($urandom);
        return bsrm_pkg::OWNER_W'($urandom_range(0, 3));
    endfunction

    // page inside a live slot's range, or the slot's base if it would overflow the page field
    function automatic logic [bsrm_pkg::PAGE_W-1:0] page_in_slot(int s);
        longint unsigned p;
        p = longint'(slot_base[s]) + $urandom_range(0, slot_count[s] - 1);
        if (p > {bsrm_pkg::PAGE_W{1'b1}})
            p = slot_base[s];
        return bsrm_pkg::PAGE_W'(p);
    endfunction

    function automatic map_cmd_t random_command();
        map_cmd_t c;
        int       pick;
        int       s;
        c = make_cmd(bsrm_pkg::CMD_W'($urandom_range(bsrm_pkg::CMD_GET_FREE,
                                                     bsrm_pkg::CMD_UNMAP)),
                     bsrm_pkg::OWNER_W'($urandom), $urandom,
                     bsrm_pkg::PAGE_W'($urandom), bsrm_pkg::INDEX_W'($urandom),
                     bsrm_pkg::COUNT_W'($urandom), 1'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 12)
            c.cmd = bsrm_pkg::CMD_GET_FREE;
        else if (pick < 22)
        begin
            c.cmd = bsrm_pkg::CMD_FREE;
            if ($urandom_range(0, 9) != 0)
                c.idx = bsrm_pkg::INDEX_W'($urandom_range(0, bsrm_pkg::ENTRIES - 1));
        end
        else if (pick < 47)
        begin
            c.cmd = bsrm_pkg::CMD_LOOKUP;
            s = pick_mapped_slot();
            if (s >= 0 && $urandom_range(0, 9) < 7)
            begin
                c.owner = slot_owner[s];
                c.vaddr = {page_in_slot(s), c.vaddr[bsrm_pkg::PAGE_SHIFT-1:0]};
            end
            else
                c.owner = pick_owner();
        end
        else if (pick < 75)
        begin
            c.cmd = bsrm_pkg::CMD_MAP;
            if ($urandom_range(0, 9) != 0)
                c.idx = bsrm_pkg::INDEX_W'($urandom_range(0, bsrm_pkg::ENTRIES - 1));
            pick = $urandom_range(0, 9);
            if (pick < 7)
                c.count = bsrm_pkg::COUNT_W'($urandom_range(1, 16));
            else if (pick < 9)
                c.count = bsrm_pkg::COUNT_W'($urandom_range(1, bsrm_pkg::MAX_PAGES));
            if (c.idx < bsrm_pkg::ENTRIES && slot_count[c.idx] != 0 &&
                $urandom_range(0, 3) != 0)
                c.count = bsrm_pkg::COUNT_W'($urandom_range(1, slot_count[c.idx]));
            if (c.idx < bsrm_pkg::ENTRIES && slot_mapped[c.idx] && $urandom_range(0, 4) != 0)
                c.owner = slot_owner[c.idx];
            else
                c.owner = pick_owner();
            if ($urandom_range(0, 9) < 8)
                c.page = bsrm_pkg::PAGE_W'($urandom_range(0, 255));
        end
        else if (pick < 95)
        begin
            c.cmd = bsrm_pkg::CMD_UNMAP;
            s = pick_mapped_slot();
            if (s >= 0 && $urandom_range(0, 9) < 7)
            begin
                c.owner = slot_owner[s];
                c.page  = $urandom_range(0, 1) ? slot_base[s] : page_in_slot(s);
            end
            else
            begin
                c.owner = pick_owner();
                c.page  = bsrm_pkg::PAGE_W'($urandom_range(0, 255));
            end
        end
        else
            c.cmd = bsrm_pkg::CMD_W'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
        return c;
    endfunction

    // receiver: long hold-off first, else the current stall pattern
    always @(negedge clk)
    begin
        rx_phase++;
        if (rx_hold_left > 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:  out_ready <= 1'b1;
                RX_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
                default:    out_ready <= (rx_phase % 7) >= 3;
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        map_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d found %0d offset %0d",
                             status, found_index, page_offset);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status || found_index !== want.found ||
                    page_offset !== want.offset)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch cmd %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.cmd, want.status, want.found, want.offset,
                                 status, found_index, page_offset);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_empty_table();
        issue_command(make_cmd(bsrm_pkg::CMD_GET_FREE, '0, '0, '0, '0, '0, 1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_LOOKUP, '0, '0, '0, '0, '0, 1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_UNMAP, '0, '0, '0, '0, '0, 1'b1));
    endtask

    task automatic test_unknown_commands();
        for (int k = CMD_RESERVED_LO; k <= CMD_RESERVED_HI; k++)
            issue_command(make_cmd(bsrm_pkg::CMD_W'(k), '1, '1, '1, '0, 8'd1, 1'b1));
    endtask

    task automatic test_map_rules();
        // slot and count range checks
        issue_command(make_cmd(bsrm_pkg::CMD_MAP, '0, '0, 20'd5,
                               bsrm_pkg::INDEX_W'(bsrm_pkg::ENTRIES), 8'd1, 1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_FREE, '0, '0, '0, '1, '0, 1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_MAP, '0, '0, 20'd5, '0, '0, 1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_MAP, '0, '0, 20'd5, '0,
                               bsrm_pkg::COUNT_W'(bsrm_pkg::MAX_PAGES + 1), 1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_MAP, '0, '0, 20'd5, '0, '1, 1'b0));
        // top page with the widest range: no wrap past the end
        issue_command(make_cmd(bsrm_pkg::CMD_MAP, '1, '0, '1, '0, bsrm_pkg::MAX_PAGES_C, 1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_LOOKUP, '1, '1, '0, '0, '0, 1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_LOOKUP, '1, 32'h0, '0, '0, '0, 1'b0));
        // foreign owner, then same-owner overwrite
        issue_command(make_cmd(bsrm_pkg::CMD_MAP, 6'd5, '0, 20'd10, '0, 8'd1, 1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_MAP, '1, '0, 20'd10, '0, bsrm_pkg::MAX_PAGES_C,
                               1'b0));
        // growth of a stored count
        issue_command(make_cmd(bsrm_pkg::CMD_MAP, '0, '0, 20'd100, 4'd1, 8'd4, 1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_MAP, '0, '0, 20'd100, 4'd1, 8'd5, 1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_LOOKUP, '0, {20'd103, 12'hfff}, '0, '0, '0,
                               1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_LOOKUP, '0, {20'd104, 12'h000}, '0, '0, '0,
                               1'b0));
        // unmap inside the range needs the any-page flag
        issue_command(make_cmd(bsrm_pkg::CMD_UNMAP, '0, '0, 20'd102, '0, '0, 1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_UNMAP, '0, '0, 20'd102, '0, '0, 1'b1));
        issue_command(make_cmd(bsrm_pkg::CMD_FREE, '0, '0, '0, 4'd0, '0, 1'b0));
        issue_command(make_cmd(bsrm_pkg::CMD_GET_FREE, '0, '0, '0, '0, '0, 1'b0));
    endtask

    task automatic test_backpressure();
        wait_for_drain();
        sender_gaps  = 1'b0;
        rx_mode      = RX_ALWAYS;
        rx_hold_left = 300;
        // fill every slot, then ask for a free one from a full table
        for (int k = 0; k < 40; k++)
            issue_command(make_cmd(bsrm_pkg::CMD_MAP, 6'd7, $urandom, bsrm_pkg::PAGE_W'(k),
                                   bsrm_pkg::INDEX_W'(k % bsrm_pkg::ENTRIES),
                                   8'd1, 1'($urandom)));
        issue_command(make_cmd(bsrm_pkg::CMD_GET_FREE, '0, '0, '0, '0, '0, 1'b0));
        wait_for_drain();
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                rx_mode     = rx_mode_t'($urandom_range(0, 2));
                sender_gaps = $urandom_range(0, 3) != 0;
            end
            if (n % 400 == 399)
                wait_for_drain();
            issue_command(random_command());
        end
    endtask

    initial
    begin
        for (int s = 0; s < bsrm_pkg::ENTRIES; s++)
            clear_slot(s);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_unknown_commands();
        test_map_rules();
        test_backpressure();
        test_random_traffic();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
